@@ src/bsrl_pkg.sv @@
// Shared types and constants for the bad track safe run lookup unit.
package bsrl_pkg;

	typedef enum logic [1:0] {
		MODE_HASH  = 2'd0,
		MODE_TREE  = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam int unsigned HASH_ENTRIES = 256;
	localparam int unsigned SLOT_W       = 10;
	localparam int unsigned HASH_W       = 8;
	localparam int unsigned TRACK_W      = 16;
	localparam int unsigned CNT_W        = 10;

	typedef struct packed {
		logic               vld;
		mode_t              mode;
		logic [SLOT_W-1:0]  slot;
		logic [HASH_W-1:0]  hval;
		logic [TRACK_W-1:0] bad_in;
		logic [TRACK_W-1:0] alt_in;
		logic [TRACK_W-1:0] track;
		logic [TRACK_W-1:0] count;
		logic               found;
		logic [TRACK_W-1:0] fbad;
		logic [TRACK_W-1:0] falt;
	} stage_t;

	typedef struct packed {
		logic [TRACK_W-1:0] bad;
		logic [TRACK_W-1:0] alt;
	} node_t;

endpackage

@@ src/bsrl_level.sv @@
// One tree level: compare against the level above, then write or read this level's bank.
module bsrl_level #(
	parameter int unsigned LEVEL  = 0,
	parameter int unsigned NODE_W = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [NODE_W-1:0]   limit,
	input  bsrl_pkg::stage_t    st_in,
	input  logic [NODE_W-1:0]   node_in,
	input  bsrl_pkg::node_t     rd_in,
	output bsrl_pkg::stage_t    st_out,
	output logic [NODE_W-1:0]   node_out,
	output bsrl_pkg::node_t     rd_out
);

	localparam int unsigned AW    = (LEVEL == 0) ? 1 : LEVEL;
	localparam int unsigned SW    = (AW > bsrl_pkg::SLOT_W) ? AW : bsrl_pkg::SLOT_W;
	localparam int unsigned DEPTH = 1 << LEVEL;

	bsrl_pkg::node_t     mem [DEPTH];
	bsrl_pkg::stage_t    st_nx;
	logic [NODE_W-1:0]   node_nx;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [SW-1:0]       slot_ext;
	logic                active;
	logic                right;
	logic                wen;

	always_comb begin
		st_nx    = st_in;
		slot_ext = SW'(st_in.slot);
		active   = (LEVEL != 0) && (st_in.mode == bsrl_pkg::MODE_QUERY) && (node_in <= limit);
		right    = st_in.track > rd_in.bad;
		if (active && !right) begin
			st_nx.found = 1'b1;
			st_nx.fbad  = rd_in.bad;
			st_nx.falt  = rd_in.alt;
		end
		if (LEVEL == 0) begin
			node_nx = NODE_W'(1);
		end else begin
			node_nx = {node_in[NODE_W-2:0], right};
		end
		if (LEVEL == 0) begin
			raddr = '0;
			waddr = '0;
		end else begin
			raddr = node_nx[AW-1:0];
			waddr = slot_ext[AW-1:0];
		end
		wen      = st_in.vld && (st_in.mode == bsrl_pkg::MODE_TREE) &&
			((slot_ext >> LEVEL) == SW'(1));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wen) begin
				mem[waddr] <= '{bad: st_in.bad_in, alt: st_in.alt_in};
			end
			rd_out <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_out.vld <= 1'b0;
		end else if (adv) begin
			st_out   <= st_nx;
			node_out <= node_nx;
		end
	end

endmodule

@@ src/bad_track_safe_run_lookup_unit.sv @@
// Top level of the bad track safe run lookup unit.
//
// Channel  Direction  Signals                          Contents
// s_*      in         s_tvalid s_tready s_tdata s_tuser  load or query word
// m_*      out        m_tvalid m_tready m_tdata m_tuser  one result word per input word
// cfg_*    in         cfg_valid cfg_ready cfg_data       bad_count register
//
// One word enters per cycle unless the result side stalls; LEVELS is the tree depth (ten for
// the default size), and each level is one pipeline stage with its own bank.
// Reset clears the valid bits and bad_count; the table and tree banks hold no reset value.
// A stall on the result side freezes the whole pipeline, memory reads included.
module bad_track_safe_run_lookup_unit #(
	parameter int unsigned MAX_BAD = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // slot, hash_value, bad_track_in, alt_track_in, track, count
	input  logic [1:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // safe_count, alternate_track
	output logic        m_tuser,  // alt_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);

	localparam int unsigned LEVELS = $clog2(MAX_BAD + 1);
	localparam int unsigned NODE_W = LEVELS + 1;
	localparam int unsigned LIM_W  = (NODE_W > bsrl_pkg::CNT_W) ? NODE_W : bsrl_pkg::CNT_W;

	logic [bsrl_pkg::CNT_W-1:0]  bad_count_q;
	logic [NODE_W-1:0]           limit;
	logic                        adv;
	logic [bsrl_pkg::HASH_W-1:0] hash_mem [bsrl_pkg::HASH_ENTRIES];
	logic [bsrl_pkg::HASH_W-1:0] hash_q;
	bsrl_pkg::stage_t            st   [LEVELS+1];
	logic [NODE_W-1:0]           node [LEVELS+1];
	bsrl_pkg::node_t             rd   [LEVELS+1];
	bsrl_pkg::stage_t            st1_patch;
	bsrl_pkg::stage_t            fin;
	logic                        fin_active;
	logic                        fin_right;
	logic [bsrl_pkg::TRACK_W-1:0] gap;
	logic                        out_vld_q;
	logic [bsrl_pkg::TRACK_W-1:0] safe_q;
	logic [bsrl_pkg::TRACK_W-1:0] alt_q;
	logic                        altv_q;
	logic [bsrl_pkg::TRACK_W-1:0] safe_nx;
	logic [bsrl_pkg::TRACK_W-1:0] alt_nx;
	logic                        altv_nx;

	assign cfg_ready = 1'b1;
	assign adv       = !out_vld_q || m_tready;
	assign s_tready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_count_q <= '0;
		end else if (cfg_valid) begin
			bad_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (LIM_W'(bad_count_q) > LIM_W'(MAX_BAD)) begin
			limit = NODE_W'(MAX_BAD);
		end else begin
			limit = NODE_W'(bad_count_q);
		end
	end

	// Input stage; the table is written and read here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st[0].vld <= 1'b0;
		end else if (adv) begin
			st[0].vld    <= s_tvalid;
			st[0].mode   <= bsrl_pkg::mode_t'(s_tuser);
			st[0].slot   <= s_tdata[9:0];
			st[0].hval   <= s_tdata[17:10];
			st[0].bad_in <= s_tdata[33:18];
			st[0].alt_in <= s_tdata[49:34];
			st[0].track  <= s_tdata[65:50];
			st[0].count  <= s_tdata[81:66];
			st[0].found  <= 1'b0;
			st[0].fbad   <= '0;
			st[0].falt   <= '0;
		end
	end

	assign node[0] = NODE_W'(1);
	assign rd[0]   = '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (st[0].vld && st[0].mode == bsrl_pkg::MODE_HASH && st[0].slot[9:8] == 2'd0) begin
				hash_mem[st[0].slot[7:0]] <= st[0].hval;
			end
			hash_q <= hash_mem[st[0].track[7:0]];
		end
	end

	// From stage one on, the hval field carries the table entry read for the query.
	always_comb begin
		st1_patch      = st[1];
		st1_patch.hval = hash_q;
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		bsrl_level #(
			.LEVEL  (k),
			.NODE_W (NODE_W)
		) u_lvl (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.limit    (limit),
			.st_in    ((k == 1) ? st1_patch : st[k]),
			.node_in  (node[k]),
			.rd_in    ((k == 0) ? rd[0] : rd[k]),
			.st_out   (st[k+1]),
			.node_out (node[k+1]),
			.rd_out   (rd[k+1])
		);
	end

	// Last level compare and result forming.
	always_comb begin
		fin        = (LEVELS == 1) ? st1_patch : st[LEVELS];
		fin_active = (fin.mode == bsrl_pkg::MODE_QUERY) && (node[LEVELS] <= limit);
		fin_right  = fin.track > rd[LEVELS].bad;
		if (fin_active && !fin_right) begin
			fin.found = 1'b1;
			fin.fbad  = rd[LEVELS].bad;
			fin.falt  = rd[LEVELS].alt;
		end
		gap     = fin.fbad - fin.track;
		safe_nx = '0;
		alt_nx  = '0;
		altv_nx = 1'b0;
		if (fin.mode == bsrl_pkg::MODE_QUERY) begin
			safe_nx = fin.count;
			if (limit != '0 && {8'd0, fin.hval} < fin.count && fin.found) begin
				safe_nx = (gap < fin.count) ? gap : fin.count;
				alt_nx  = fin.falt;
				altv_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= fin.vld;
			safe_q    <= safe_nx;
			alt_q     <= alt_nx;
			altv_q    <= altv_nx;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {alt_q, safe_q};
	assign m_tuser  = altv_q;

endmodule
